>>> rtl/awam_pkg.sv
// Shared types and codes for the add-with-carry block.
// Holds opcode and addressing mode codes, stream widths and the store control struct.
// No dependencies.
package awam_pkg;

  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 6;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 1;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_ADC   = 2'd2;

  localparam logic [3:0] MODE_IMM   = 4'd0;
  localparam logic [3:0] MODE_ZP    = 4'd1;
  localparam logic [3:0] MODE_ZP_X  = 4'd2;
  localparam logic [3:0] MODE_ABS   = 4'd3;
  localparam logic [3:0] MODE_ABS_X = 4'd4;
  localparam logic [3:0] MODE_ABS_Y = 4'd5;
  localparam logic [3:0] MODE_IND_X = 4'd6;
  localparam logic [3:0] MODE_IND_Y = 4'd7;

  typedef struct packed {
    logic wr;
    logic rd;
  } mem_ctrl_t;

endpackage

>>> rtl/awam_ram.sv
// Single-port byte store with registered read data.
// Depends on awam_pkg for the control struct.
module awam_ram #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  awam_pkg::mem_ctrl_t  ctrl,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [7:0]           wdata,
  output logic [7:0]           rdata
);
  import awam_pkg::*;

  logic [7:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctrl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/adc_with_addressing_modes_top.sv
// Top level of the add-with-carry block: sequencer, shared adder, accumulator and flags.
// Depends on awam_pkg and awam_ram.
//
// One item is in work at a time. After an item is transferred, the sequencer goes
// straight to the finish step for a store write, a load, an immediate add, an invalid
// mode or the unused opcode, through the address step for the zero page and absolute
// modes, and through the address, pointer-high and target steps for both indirect modes.
// The finish step loads the result register once the output is free, and the sequencer
// then returns to idle. The steps are set by the single read port of the byte store,
// whose registered data feeds each dependent address step, and by one 16-bit adder that
// forms every read address and the sum. A finished result waits in an output register,
// so the next item is taken while it waits. The store needs no clearing after reset
// and holds nothing defined until written.
module adc_with_addressing_modes_top #(
  parameter int ADDR_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // operand[15:0], write_data[23:16], carry_load[24], x_index[32:25], y_index[40:33]
  input  logic [awam_pkg::IN_TDATA_W-1:0]  in_tdata,
  // opcode[1:0], addressing_mode[5:2]
  input  logic [awam_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // acc_out[7:0], carry_out[8], overflow_out[9], zero_out[10], negative_out[11]
  output logic [awam_pkg::OUT_TDATA_W-1:0] out_tdata,
  // bad_mode[0]
  output logic [awam_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import awam_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ADDR   = 5'b00010,
    S_PTR_HI = 5'b00100,
    S_TGT    = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;

  logic [1:0]  op_r;
  logic [3:0]  mode_r;
  logic [15:0] opnd_r;
  logic [7:0]  wdata_r;
  logic        cload_r;
  logic [7:0]  x_r;
  logic [7:0]  y_r;
  logic [7:0]  ptr_r;
  logic [7:0]  lo_r;

  logic [7:0]  acc_r, acc_nxt;
  logic        carry_r, carry_nxt;
  logic        ovf_r, ovf_nxt;
  logic        zero_r, zero_nxt;
  logic        neg_r, neg_nxt;
  logic        bad;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [OUT_TUSER_W-1:0] out_tuser_r;

  logic [15:0] add_a;
  logic [15:0] add_b;
  logic        add_cin;
  logic [16:0] add_sum;

  mem_ctrl_t   mem_ctrl;
  logic [15:0] mem_addr;
  logic [7:0]  rd_data;

  logic        in_xfer;
  logic        fin_go;
  logic        in_direct;
  logic        mode_wide;
  logic        mode_ind;
  logic [7:0]  idx;
  logic [7:0]  m_byte;
  logic [7:0]  res;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign fin_go     = !out_valid_r || out_tready;

  assign in_direct = (in_tuser[1:0] == OP_ADC) && (in_tuser[5:2] != MODE_IMM) &&
                     (in_tuser[5:2] <= MODE_IND_Y);

  assign mode_wide = (mode_r == MODE_ABS) || (mode_r == MODE_ABS_X) ||
                     (mode_r == MODE_ABS_Y);
  assign mode_ind  = (mode_r == MODE_IND_X) || (mode_r == MODE_IND_Y);
  assign idx = ((mode_r == MODE_ZP_X) || (mode_r == MODE_ABS_X) || (mode_r == MODE_IND_X))
               ? x_r : ((mode_r == MODE_ABS_Y) ? y_r : 8'h00);

  assign m_byte  = (mode_r == MODE_IMM) ? opnd_r[7:0] : rd_data;
  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {16'h0000, add_cin};
  assign res     = add_sum[7:0];
  assign bad     = (op_r == OP_ADC) && (mode_r > MODE_IND_Y);

  always_comb begin
    state_nxt = state_r;
    add_a     = 16'h0000;
    add_b     = 16'h0000;
    add_cin   = 1'b0;
    mem_ctrl  = '0;
    mem_addr  = 16'h0000;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = in_direct ? S_ADDR : S_FIN;
        end
      end
      S_ADDR: begin
        add_a       = mode_wide ? opnd_r : {8'h00, opnd_r[7:0]};
        add_b       = {8'h00, idx};
        mem_addr    = mode_wide ? add_sum[15:0] : {8'h00, add_sum[7:0]};
        mem_ctrl.rd = 1'b1;
        state_nxt   = mode_ind ? S_PTR_HI : S_FIN;
      end
      S_PTR_HI: begin
        add_a       = {8'h00, ptr_r};
        add_cin     = 1'b1;
        mem_addr    = {8'h00, add_sum[7:0]};
        mem_ctrl.rd = 1'b1;
        state_nxt   = S_TGT;
      end
      S_TGT: begin
        add_a       = {rd_data, lo_r};
        add_b       = (mode_r == MODE_IND_Y) ? {8'h00, y_r} : 16'h0000;
        mem_addr    = add_sum[15:0];
        mem_ctrl.rd = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        add_a   = {8'h00, acc_r};
        add_b   = {8'h00, m_byte};
        add_cin = carry_r;
        if (fin_go) begin
          state_nxt = S_IDLE;
          if (op_r == OP_WRITE) begin
            mem_ctrl.wr = 1'b1;
            mem_addr    = opnd_r;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    acc_nxt   = acc_r;
    carry_nxt = carry_r;
    ovf_nxt   = ovf_r;
    zero_nxt  = zero_r;
    neg_nxt   = neg_r;
    if (op_r == OP_LOAD) begin
      acc_nxt   = wdata_r;
      carry_nxt = cload_r;
    end else if ((op_r == OP_ADC) && !bad) begin
      acc_nxt   = res;
      carry_nxt = add_sum[8];
      ovf_nxt   = ((res[7] ^ acc_r[7]) & (res[7] ^ m_byte[7]));
      zero_nxt  = (res == 8'h00);
      neg_nxt   = res[7];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= 8'h00;
      carry_r     <= 1'b0;
      ovf_r       <= 1'b0;
      zero_r      <= 1'b0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_FIN) && fin_go) begin
        acc_r       <= acc_nxt;
        carry_r     <= carry_nxt;
        ovf_r       <= ovf_nxt;
        zero_r      <= zero_nxt;
        neg_r       <= neg_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r    <= in_tuser[1:0];
      mode_r  <= in_tuser[5:2];
      opnd_r  <= in_tdata[15:0];
      wdata_r <= in_tdata[23:16];
      cload_r <= in_tdata[24];
      x_r     <= in_tdata[32:25];
      y_r     <= in_tdata[40:33];
    end
    if (state_r == S_ADDR) begin
      ptr_r <= add_sum[7:0];
    end
    if (state_r == S_PTR_HI) begin
      lo_r <= rd_data;
    end
    if ((state_r == S_FIN) && fin_go) begin
      out_tdata_r <= {4'h0, neg_nxt, zero_nxt, ovf_nxt, carry_nxt, acc_nxt};
      out_tuser_r <= bad;
    end
  end

  awam_ram #(
    .ADDR_BITS(ADDR_BITS)
  ) u_ram (
    .clk  (clk),
    .ctrl (mem_ctrl),
    .addr (mem_addr[ADDR_BITS-1:0]),
    .wdata(wdata_r),
    .rdata(rd_data)
  );

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctrl.wr && mem_ctrl.rd))
    else $error("store read and write in the same cycle");

  a_wr_only_fin: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctrl.wr |-> (state_r == S_FIN) && (op_r == OP_WRITE))
    else $error("store write outside the finish step of a write");

  a_fetch_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_direct) |=> (state_r == S_ADDR))
    else $error("fetching add did not start address step");

  a_bad_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && fin_go && bad) |=> (acc_r == $past(acc_r)) &&
    (carry_r == $past(carry_r)))
    else $error("invalid mode changed accumulator state");

  a_result_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && fin_go) |=> out_valid_r && (state_r == S_IDLE))
    else $error("finish step did not load result");

endmodule
